// ===== sv/sca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sca_pkg;
    localparam int CordicStepsDefault = 16;
    localparam int AtanLen = 24;
    localparam logic [15:0] SineFloorReset = 16'd427;
    localparam logic [15:0] SineCeilingReset = 16'd65388;
    localparam logic [15:0] CosineFloorReset = 16'd608;
    localparam logic [15:0] CosineCeilingReset = 16'd64743;

    localparam logic [1:0] RegSineFloor = 2'd0;
    localparam logic [1:0] RegSineCeiling = 2'd1;
    localparam logic [1:0] RegCosineFloor = 2'd2;
    localparam logic [1:0] RegCosineCeiling = 2'd3;

    // job handed from front to back
    typedef struct packed {
        logic [15:0] cs;
        logic [15:0] cc;
        logic [15:0] smin;
        logic [15:0] smax;
        logic [15:0] cmin;
        logic [15:0] cmax;
        logic        ok;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_ROT,
        ST_SCALE,
        ST_DONE
    } back_state_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'h20000000;
                5'd1: r = 32'h12E4051E;
                5'd2: r = 32'h09FB385B;
                5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43;
                5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E;
                5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53;
                5'd9: r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== sv/sincos_encoder_angle.sv =====
`timescale 1ns / 1ps
`default_nettype none
// sine/cosine encoder angle: one sample pair in, one angle out. The front
// clamps samples, updates learned bounds and hands a job to a two-entry
// queue in the same cycle it takes the item. The back runs two bit-serial
// dividers, min(CORDIC_STEPS, 24) steps of one shared rotation stage and
// one scaling multiply, taking a new job only once the last angle is taken
// (skipped if a bound range is empty). Config writes are always ready.
module sincos_encoder_angle
    import sca_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] sine_sample,
    input  wire logic [15:0] cosine_sample,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      angle_centideg,
    output logic             angle_valid,
    output logic [15:0]      sine_low_bound,
    output logic [15:0]      sine_high_bound,
    output logic [15:0]      cosine_low_bound,
    output logic [15:0]      cosine_high_bound
);
    job_t fj, bj;
    logic fv, fr, bv, br;

    sca_front u_front (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .in_valid, .in_ready, .sine_sample, .cosine_sample,
        .job_valid(fv), .job_ready(fr), .job(fj)
    );

    sca_queue u_queue (
        .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_job(fj),
        .rd_valid(bv), .rd_ready(br), .rd_job(bj)
    );

    sca_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk, .rst_n, .job_valid(bv), .job_ready(br), .job(bj),
        .out_valid, .out_ready, .angle_centideg, .angle_valid,
        .sine_low_bound, .sine_high_bound, .cosine_low_bound, .cosine_high_bound
    );
endmodule
`default_nettype wire

// ===== sv/sca_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sca_front
    import sca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] sine_sample,
    input  wire logic [15:0] cosine_sample,
    output logic             job_valid,
    input  wire logic        job_ready,
    output job_t             job
);
    logic [15:0] sfl_reg, sce_reg, cfl_reg, cce_reg;
    logic [15:0] smin_reg, smax_reg, cmin_reg, cmax_reg;
    logic [15:0] cs1, cs, cc1, cc, smin_n, smax_n, cmin_n, cmax_n;
    logic        acc;

    assign cfg_ready = 1'b1;
    assign in_ready = job_ready;
    assign job_valid = in_valid;
    assign acc = in_valid && job_ready;

    always_comb
    begin
        cs1 = (sine_sample < sfl_reg) ? sfl_reg : sine_sample;
        cs = (cs1 > sce_reg) ? sce_reg : cs1;
        cc1 = (cosine_sample < cfl_reg) ? cfl_reg : cosine_sample;
        cc = (cc1 > cce_reg) ? cce_reg : cc1;
        smin_n = (cs < smin_reg) ? cs : smin_reg;
        smax_n = (cs > smax_reg) ? cs : smax_reg;
        cmin_n = (cc < cmin_reg) ? cc : cmin_reg;
        cmax_n = (cc > cmax_reg) ? cc : cmax_reg;
        job.cs = cs;
        job.cc = cc;
        job.smin = smin_n;
        job.smax = smax_n;
        job.cmin = cmin_n;
        job.cmax = cmax_n;
        job.ok = (smax_n > smin_n) && (cmax_n > cmin_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sfl_reg <= SineFloorReset;
            sce_reg <= SineCeilingReset;
            cfl_reg <= CosineFloorReset;
            cce_reg <= CosineCeilingReset;
            smin_reg <= SineCeilingReset;
            smax_reg <= SineFloorReset;
            cmin_reg <= CosineCeilingReset;
            cmax_reg <= CosineFloorReset;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    RegSineFloor: sfl_reg <= cfg_data;
                    RegSineCeiling: sce_reg <= cfg_data;
                    RegCosineFloor: cfl_reg <= cfg_data;
                    RegCosineCeiling: cce_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (acc)
            begin
                smin_reg <= smin_n;
                smax_reg <= smax_n;
                cmin_reg <= cmin_n;
                cmax_reg <= cmax_n;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/sca_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sca_queue
    import sca_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  job_t      wr_job,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output job_t      rd_job
);
    // two-entry queue
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

// ===== sv/sca_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sca_back
    import sca_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  job_t             job,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      angle_centideg,
    output logic             angle_valid,
    output logic [15:0]      sine_low_bound,
    output logic [15:0]      sine_high_bound,
    output logic [15:0]      cosine_low_bound,
    output logic [15:0]      cosine_high_bound
);
    localparam int Steps = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;
    localparam logic [4:0] LastStep = 5'(Steps - 1);

    back_state_t state_reg, state_next;
    job_t        job_reg;
    // two restoring dividers run side by side, one quotient bit a cycle
    logic [16:0] sr_reg, cr_reg;
    logic [16:0] sq_reg, cq_reg;
    logic [4:0]  cnt_reg;
    logic signed [27:0] x_reg, y_reg;
    logic [31:0] z_reg;
    logic [15:0] prod_reg;
    logic        sq_valid_reg;
    logic        ld, step_div, step_rot, ld_rot, sc, fin;
    logic [15:0] sden, cden;
    logic [17:0] str, ctr;
    logic signed [27:0] xs, ys, sx, cx;
    logic [47:0] prod;

    assign sden = job_reg.smax - job_reg.smin;
    assign cden = job_reg.cmax - job_reg.cmin;
    assign str = {sr_reg, 1'b0} - {2'b0, sden};
    assign ctr = {cr_reg, 1'b0} - {2'b0, cden};
    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign sx = 28'(signed'({1'b0, sq_reg}) - 28'sd32768) <<< 8;
    assign cx = 28'(signed'({1'b0, cq_reg}) - 28'sd32768) <<< 8;
    assign prod = {16'b0, z_reg} * 48'd36000 + 48'h80000000;

    always_comb
    begin
        state_next = state_reg;
        job_ready = 1'b0;
        out_valid = 1'b0;
        ld = 1'b0;
        step_div = 1'b0;
        ld_rot = 1'b0;
        step_rot = 1'b0;
        sc = 1'b0;
        fin = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    ld = 1'b1;
                    state_next = job.ok ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                step_div = 1'b1;
                if (cnt_reg == 5'd16)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                ld_rot = 1'b1;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                step_rot = 1'b1;
                if (cnt_reg == LastStep)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                sc = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    fin = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            job_reg <= job;
            sr_reg <= {1'b0, job.cs - job.smin};
            cr_reg <= {1'b0, job.cc - job.cmin};
            sq_reg <= '0;
            cq_reg <= '0;
            cnt_reg <= '0;
            prod_reg <= '0;
        end
        if (step_div)
        begin
            // 17 quotient bits: numerator already holds the first bit position
            if (cnt_reg == 5'd0)
            begin
                sq_reg <= {16'b0, (sr_reg >= {1'b0, sden})};
                cq_reg <= {16'b0, (cr_reg >= {1'b0, cden})};
                sr_reg <= (sr_reg >= {1'b0, sden}) ? sr_reg - {1'b0, sden} : sr_reg;
                cr_reg <= (cr_reg >= {1'b0, cden}) ? cr_reg - {1'b0, cden} : cr_reg;
            end
            else
            begin
                sq_reg <= {sq_reg[15:0], ~str[17]};
                cq_reg <= {cq_reg[15:0], ~ctr[17]};
                sr_reg <= str[17] ? {sr_reg[15:0], 1'b0} : str[16:0];
                cr_reg <= ctr[17] ? {cr_reg[15:0], 1'b0} : ctr[16:0];
            end
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (ld_rot)
        begin
            cnt_reg <= '0;
            if (cx < 0)
            begin
                x_reg <= -cx;
                y_reg <= -sx;
                z_reg <= 32'h80000000;
            end
            else
            begin
                x_reg <= cx;
                y_reg <= sx;
                z_reg <= '0;
            end
            job_reg.ok <= ~(cx == 0 && sx == 0);
        end
        if (step_rot)
        begin
            if (!y_reg[27])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_turn(cnt_reg);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_turn(cnt_reg);
            end
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (sc)
            prod_reg <= job_reg.ok ? prod[47:32] : '0;
    end

    // angle is valid whenever both ranges were nonempty, even for a zero vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else if (ld)
            sq_valid_reg <= job.ok;
        else if (fin)
            sq_valid_reg <= 1'b0;
    end

    assign angle_centideg = prod_reg;
    assign angle_valid = sq_valid_reg;
    assign sine_low_bound = job_reg.smin;
    assign sine_high_bound = job_reg.smax;
    assign cosine_low_bound = job_reg.cmin;
    assign cosine_high_bound = job_reg.cmax;
endmodule
`default_nettype wire
